>>> rtl/core/vrr_pkg.sv
`default_nettype none
package vrr_pkg;

   localparam int CompW  = 16;
   localparam int IndexW = 15;
   localparam int EtaW   = 19;
   localparam int RootW  = 29;
   localparam int RadW   = 57;
   localparam logic [EtaW-1:0] EtaMax = 19'h7FFFF;
   localparam int OutMax = 16384;
   localparam int DivSteps = 31;

   typedef enum logic {
      CMD_REFLECT = 1'b0,
      CMD_REFRACT = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                  command;
      logic signed [CompW-1:0]  dir_x;
      logic signed [CompW-1:0]  dir_y;
      logic signed [CompW-1:0]  dir_z;
      logic signed [CompW-1:0]  norm_x;
      logic signed [CompW-1:0]  norm_y;
      logic signed [CompW-1:0]  norm_z;
      logic [IndexW-1:0]        index_source;
      logic [IndexW-1:0]        index_target;
   } req_type;

   typedef struct packed {
      logic signed [CompW-1:0] out_x;
      logic signed [CompW-1:0] out_y;
      logic signed [CompW-1:0] out_z;
      logic                    internal_reflection;
   } rsp_type;

   // Round a Q42 value to Q14 (nearest, ties up) and saturate to +/-1.0.
   function automatic logic signed [CompW-1:0] sat_q42(input logic signed [63:0] v);
      logic signed [63:0] r;
      begin
         r = (v + 64'sd134217728) >>> 28;
         if (r > 64'sd16384) r = 64'sd16384;
         if (r < -64'sd16384) r = -64'sd16384;
         sat_q42 = r[CompW-1:0];
      end
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/vector_reflect_refract_unit_core.sv
`default_nettype none
// Reflect / refract unit. Takes one word per cycle on req_ while req_ready is high and
// returns one word per word on rsp_, in order. Stages: 31 of a restoring divider (one
// quotient bit each) for eta = n1/n2, three for eta saturation with cos_i clamp, squares
// and products, 29 of a one-bit-per-stage square root, then coefficient, product and
// output stages. The whole pipe advances when the output register is empty or being
// taken, so throughput is one word per cycle while rsp_ready is high. Reflect words
// ride the same pipe and leave with internal_reflection low.
// Refract words with total internal reflection return the mirror reflection, flag set.
module vector_reflect_refract_unit_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire vrr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output vrr_pkg::rsp_type      rsp_data
);
   import vrr_pkg::*;

   localparam int NDiv = DivSteps;
   localparam int NSq  = RootW;

   // shared context carried along the pipe
   typedef struct packed {
      cmd_type             cmd;
      logic signed [15:0]  dx, dy, dz, nx, ny, nz;
      logic signed [33:0]  dot;
   } ctx_type;

   logic adv;
   logic out_vld_ff;
   rsp_type out_ff;

   // advance whole pipe when output slot frees
   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 0: dot product, divider setup
   ctx_type c0_in;
   logic [30:0] rem0_in;
   logic [14:0] dvs0_in;
   always_comb begin
      c0_in.cmd = req_data.command;
      c0_in.dx = req_data.dir_x;  c0_in.dy = req_data.dir_y;  c0_in.dz = req_data.dir_z;
      c0_in.nx = req_data.norm_x; c0_in.ny = req_data.norm_y; c0_in.nz = req_data.norm_z;
      c0_in.dot = 34'(req_data.dir_x * req_data.norm_x)
                + 34'(req_data.dir_y * req_data.norm_y)
                + 34'(req_data.dir_z * req_data.norm_z);
      rem0_in = {req_data.index_source, 16'd0};
      dvs0_in = (req_data.index_target == '0) ? 15'd1 : req_data.index_target;
   end

   // divider stages: state = {ctx, partial remainder, divisor, dividend, quotient}
   localparam int DW = $bits(ctx_type) + 16 + 15 + 31 + 31;
   logic [DW-1:0] dv_d [NDiv+1];
   logic          dv_v [NDiv+1];
   assign dv_d[0] = {c0_in, 16'd0, dvs0_in, rem0_in, 31'd0};
   assign dv_v[0] = req_valid;

   for (genvar k = 0; k < NDiv; k++) begin : g_div
      ctx_type     c;
      logic [15:0] r;
      logic [14:0] dvs;
      logic [30:0] dd, q;
      logic [16:0] t;
      logic [DW-1:0] nx;
      always_comb begin
         {c, r, dvs, dd, q} = dv_d[k];
         t = {r, dd[30]};
         if (t >= {2'b0, dvs}) begin
            t = t - {2'b0, dvs};
            q = {q[29:0], 1'b1};
         end else begin
            q = {q[29:0], 1'b0};
         end
         nx = {c, t[15:0], dvs, {dd[29:0], 1'b0}, q};
      end
      vrr_pipe #(.Width(DW)) u_st (.clock, .reset, .adv, .vld_in(dv_v[k]),
         .dat_in(nx), .vld_ff(dv_v[k+1]), .dat_ff(dv_d[k+1]));
   end

   // ---------------- stage A: eta saturate, cos_i clamp
   ctx_type ca;
   logic [30:0] qa;
   assign ca = dv_d[NDiv][DW-1 -: $bits(ctx_type)];
   assign qa = dv_d[NDiv][30:0];

   typedef struct packed {
      ctx_type            c;
      logic [EtaW-1:0]    eta;
      logic signed [29:0] cosi;
   } sa_type;
   sa_type sa_in, sa_q; logic sa_v;
   always_comb begin
      sa_in.c = ca;
      sa_in.eta = (qa > 31'(EtaMax)) ? EtaMax : qa[EtaW-1:0];
      if (-ca.dot > 34'sd268435456) sa_in.cosi = 30'sd268435456;
      else if (-ca.dot < -34'sd268435456) sa_in.cosi = -30'sd268435456;
      else sa_in.cosi = 30'(-ca.dot);
   end
   vrr_pipe #(.Width($bits(sa_type))) u_sa (.clock, .reset, .adv, .vld_in(dv_v[NDiv]),
      .dat_in(sa_in), .vld_ff(sa_v), .dat_ff(sa_q));

   // ---------------- stage B: cos^2 and eta^2
   typedef struct packed {
      ctx_type            c;
      logic [EtaW-1:0]    eta;
      logic signed [29:0] cosi;
      logic [28:0]        s;
      logic [33:0]        eta2;
   } sb_type;
   sb_type sb_in, sb_q; logic sb_v;
   logic [57:0] cc;
   always_comb begin
      cc = 58'(sa_q.cosi * sa_q.cosi);
      sb_in.c = sa_q.c; sb_in.eta = sa_q.eta; sb_in.cosi = sa_q.cosi;
      sb_in.s = 29'((58'd1 << 56) - cc >> 28);
      sb_in.eta2 = 34'((38'(sa_q.eta) * 38'(sa_q.eta)) >> 4);
   end
   vrr_pipe #(.Width($bits(sb_type))) u_sb (.clock, .reset, .adv, .vld_in(sa_v),
      .dat_in(sb_in), .vld_ff(sb_v), .dat_ff(sb_q));

   // ---------------- stage C: sin_t^2, eta*cos_i
   typedef struct packed {
      ctx_type            c;
      logic [EtaW-1:0]    eta;
      logic               tir;
      logic [RadW-1:0]    rad;
      logic signed [35:0] ec;
   } sc_type;
   sc_type sc_in, sc_q; logic sc_v;
   logic [62:0] st2;
   logic signed [49:0] ecw;
   always_comb begin
      st2 = 63'(sb_q.eta2) * 63'(sb_q.s);
      ecw = 50'(signed'({1'b0, sb_q.eta})) * 50'(sb_q.cosi);
      sc_in.c = sb_q.c; sc_in.eta = sb_q.eta;
      sc_in.tir = st2 > (63'd1 << 56);
      sc_in.rad = sc_in.tir ? '0 : RadW'((63'd1 << 56) - st2);
      sc_in.ec = 36'((ecw + 50'sd32768) >>> 16);
   end
   vrr_pipe #(.Width($bits(sc_type))) u_sc (.clock, .reset, .adv, .vld_in(sb_v),
      .dat_in(sc_in), .vld_ff(sc_v), .dat_ff(sc_q));

   // ---------------- square root: one root bit per stage
   localparam int SW = $bits(sc_type) + 58 + RootW;
   logic [SW-1:0] sq_d [NSq+1];
   logic          sq_v [NSq+1];
   assign sq_d[0] = {sc_q, 58'(sc_q.rad), {RootW{1'b0}}};
   assign sq_v[0] = sc_v;
   for (genvar k = 0; k < NSq; k++) begin : g_sq
      localparam int B = NSq - 1 - k;
      sc_type        s;
      logic [57:0]   x, trial;
      logic [RootW-1:0] r;
      logic [SW-1:0] nx;
      always_comb begin
         {s, x, r} = sq_d[k];
         trial = (58'(r) << (B + 1)) + (58'd1 << (2 * B));
         if (x >= trial) begin
            x = x - trial;
            r = r | (RootW'(1) << B);
         end
         nx = {s, x, r};
      end
      vrr_pipe #(.Width(SW)) u_st (.clock, .reset, .adv, .vld_in(sq_v[k]),
         .dat_in(nx), .vld_ff(sq_v[k+1]), .dat_ff(sq_d[k+1]));
   end

   // ---------------- stage D: coefficient
   sc_type sd; logic [RootW-1:0] sd_r;
   assign sd   = sq_d[NSq][SW-1 -: $bits(sc_type)];
   assign sd_r = sq_d[NSq][RootW-1:0];
   typedef struct packed {
      ctx_type            c;
      logic [EtaW-1:0]    eta;
      logic               tir;
      logic signed [36:0] coef;
   } se_type;
   se_type se_in, se_q; logic se_v;
   always_comb begin
      se_in.c = sd.c; se_in.eta = sd.eta; se_in.tir = sd.tir;
      se_in.coef = 37'(sd.ec) - 37'(signed'({1'b0, sd_r}));
   end
   vrr_pipe #(.Width($bits(se_type))) u_se (.clock, .reset, .adv, .vld_in(sq_v[NSq]),
      .dat_in(se_in), .vld_ff(se_v), .dat_ff(se_q));

   // ---------------- stage E: products per component
   typedef struct packed {
      logic               refl, tir;
      logic signed [55:0] ax, ay, az, bx, by, bz;
   } sf_type;
   sf_type sf_in, sf_q; logic sf_v;
   logic signed [19:0] eta_s;
   logic signed [34:0] dot2;
   always_comb begin
      eta_s = signed'({1'b0, se_q.eta});
      dot2  = 35'(se_q.c.dot) <<< 1;
      sf_in.tir  = (se_q.c.cmd == CMD_REFRACT) && se_q.tir;
      sf_in.refl = (se_q.c.cmd == CMD_REFLECT) || se_q.tir;
      if (sf_in.refl) begin
         sf_in.ax = 56'(se_q.c.dx) <<< 28;
         sf_in.ay = 56'(se_q.c.dy) <<< 28;
         sf_in.az = 56'(se_q.c.dz) <<< 28;
         sf_in.bx = -56'(dot2 * se_q.c.nx);
         sf_in.by = -56'(dot2 * se_q.c.ny);
         sf_in.bz = -56'(dot2 * se_q.c.nz);
      end else begin
         sf_in.ax = 56'(eta_s * se_q.c.dx) <<< 12;
         sf_in.ay = 56'(eta_s * se_q.c.dy) <<< 12;
         sf_in.az = 56'(eta_s * se_q.c.dz) <<< 12;
         sf_in.bx = 56'(se_q.coef * se_q.c.nx);
         sf_in.by = 56'(se_q.coef * se_q.c.ny);
         sf_in.bz = 56'(se_q.coef * se_q.c.nz);
      end
   end
   vrr_pipe #(.Width($bits(sf_type))) u_sf (.clock, .reset, .adv, .vld_in(se_v),
      .dat_in(sf_in), .vld_ff(sf_v), .dat_ff(sf_q));

   // ---------------- output register: sum, round, saturate
   rsp_type out_in;
   always_comb begin
      out_in.out_x = sat_q42(64'(sf_q.ax) + 64'(sf_q.bx));
      out_in.out_y = sat_q42(64'(sf_q.ay) + 64'(sf_q.by));
      out_in.out_z = sat_q42(64'(sf_q.az) + 64'(sf_q.bz));
      out_in.internal_reflection = sf_q.tir;
   end
   vrr_pipe #(.Width($bits(rsp_type))) u_out (.clock, .reset, .adv, .vld_in(sf_v),
      .dat_in(out_in), .vld_ff(out_vld_ff), .dat_ff(out_ff));

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

`ifndef NO_ASSERTIONS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");
   a_flag: assert property (@(posedge clock) disable iff (reset)
      sf_v && sf_q.tir |-> sf_q.refl)
      else $error("flag without reflection");
`endif
endmodule
`default_nettype wire

>>> rtl/core/vrr_pipe.sv
`default_nettype none
// Pipeline register stage with a shared advance enable: holds a payload with its valid bit.
module vrr_pipe #(
   parameter int Width = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             vld_in,
   input  wire logic [Width-1:0] dat_in,
   output logic                  vld_ff,
   output logic [Width-1:0]      dat_ff
);
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         dat_ff <= dat_in;
      end
   end
endmodule
`default_nettype wire

>>> test/vector_reflect_refract_unit_core_tb.sv
module vector_reflect_refract_unit_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vrr_pkg::*;

   localparam int PipeDepth  = 66;
   localparam int StallLimit = 20000;
   localparam int RandWords  = 400;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   vector_reflect_refract_unit_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Free-running clock, 20 ns period.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Results still owed by the block, oldest first.
   rsp_type pending_dirs[$];
   int      fail_count;
   int      idle_cycles;
   int      send_idle_pct;
   int      recv_idle_pct;

   // One row of the directed table: the word to send, and optionally a
   // hand-typed expectation to check against the computed one.
   typedef struct {
      req_type word;
      logic    typed;
      rsp_type want;
   } vec_row_type;

   // Round a Q42 value to Q14 (nearest, ties toward +inf), clamp to +/-1.0.
   function automatic logic signed [15:0] round_clamp_q42(longint v);
      longint r;
      r = (v + (longint'(1) << 27)) >>> 28;
      if (r > OutMax) r = OutMax;
      if (r < -OutMax) r = -OutMax;
      return r[15:0];
   endfunction

   // Bitwise integer square root of a 64-bit unsigned value.
   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Compute the reflected or refracted direction for one request word.
   function automatic rsp_type bend_ray(req_type w);
      longint          d[3];
      longint          n[3];
      longint          dot;
      longint          cosi;
      longint          coef;
      longint unsigned n1;
      longint unsigned n2;
      longint unsigned eta;
      longint unsigned s;
      longint unsigned eta2;
      longint unsigned sint2;
      longint unsigned root;
      logic            tir;
      rsp_type         r;
      logic signed [15:0] o[3];
      d[0] = w.dir_x;  d[1] = w.dir_y;  d[2] = w.dir_z;
      n[0] = w.norm_x; n[1] = w.norm_y; n[2] = w.norm_z;
      dot = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
      tir = 1'b0;
      r.internal_reflection = 1'b0;
      if (w.command == CMD_REFRACT) begin
         n1 = w.index_source;
         n2 = w.index_target;
         // zero target index behaves as one LSB
         if (n2 == 0) n2 = 1;
         eta = (n1 << 16) / n2;
         if (eta > EtaMax) eta = EtaMax;
         cosi = -dot;
         if (cosi > (longint'(1) << 28)) cosi = longint'(1) << 28;
         if (cosi < -(longint'(1) << 28)) cosi = -(longint'(1) << 28);
         s = ((64'd1 << 56) - longint'(cosi * cosi)) >> 28;
         eta2 = (eta * eta) >> 4;
         sint2 = eta2 * s;
         if (sint2 <= (64'd1 << 56)) begin
            root = int_sqrt((64'd1 << 56) - sint2);
            coef = ((longint'(eta) * cosi + (longint'(1) << 15)) >>> 16) - longint'(root);
            for (int i = 0; i < 3; i++)
               o[i] = round_clamp_q42(longint'(eta) * d[i] * 4096 + coef * n[i]);
            r.out_x = o[0]; r.out_y = o[1]; r.out_z = o[2];
            return r;
         end
         tir = 1'b1;
      end
      r.internal_reflection = tir;
      for (int i = 0; i < 3; i++)
         o[i] = round_clamp_q42(d[i] * (longint'(1) << 28) - 2 * dot * n[i]);
      r.out_x = o[0]; r.out_y = o[1]; r.out_z = o[2];
      return r;
   endfunction

   function automatic req_type make_word(cmd_type c, int dx, int dy, int dz,
                                         int nx, int ny, int nz, int n1, int n2);
      req_type w;
      w.command = c;
      w.dir_x = 16'(dx); w.dir_y = 16'(dy); w.dir_z = 16'(dz);
      w.norm_x = 16'(nx); w.norm_y = 16'(ny); w.norm_z = 16'(nz);
      w.index_source = n1[14:0];
      w.index_target = n2[14:0];
      return w;
   endfunction

   function automatic rsp_type make_dir(int x, int y, int z, logic f);
      rsp_type r;
      r.out_x = 16'(x); r.out_y = 16'(y); r.out_z = 16'(z); r.internal_reflection = f;
      return r;
   endfunction

   // Random component, mostly in range, sometimes any 16-bit pattern.
   function automatic int rand_comp();
      if ($urandom_range(9) == 0) return int'($signed(16'($urandom)));
      return $urandom_range(32768) - 16384;
   endfunction

   // Random word: mostly a roughly unit direction against a unit normal.
   function automatic req_type rand_word();
      req_type w;
      int      axis;
      int      a;
      int      b;
      w.command = cmd_type'($urandom_range(1));
      if ($urandom_range(3) == 0) begin
         w.dir_x = 16'(rand_comp()); w.dir_y = 16'(rand_comp());
         w.dir_z = 16'(rand_comp());
         w.norm_x = 16'(rand_comp()); w.norm_y = 16'(rand_comp());
         w.norm_z = 16'(rand_comp());
      end else begin
         // shallow-to-steep hits along a random axis
         a = $urandom_range(16384);
         b = int'($sqrt(real'(16384 * 16384 - a * a)));
         axis = $urandom_range(2);
         w.norm_x = (axis == 0) ? 16'sd16384 : 16'sd0;
         w.norm_y = (axis == 1) ? 16'sd16384 : 16'sd0;
         w.norm_z = (axis == 2) ? 16'sd16384 : 16'sd0;
         w.dir_x = 16'((axis == 0) ? -b : a);
         w.dir_y = 16'((axis == 1) ? -b : ((axis == 0) ? a : 0));
         w.dir_z = 16'((axis == 2) ? -b : 0);
         if ($urandom_range(1)) w.dir_x = -w.dir_x;
      end
      case ($urandom_range(4))
         0:       w.index_source = 15'($urandom);
         1:       w.index_source = 15'd4096;
         default: w.index_source = 15'($urandom_range(32767, 4096));
      endcase
      case ($urandom_range(5))
         0:       w.index_target = 15'($urandom);
         1:       w.index_target = 15'd0;
         default: w.index_target = 15'($urandom_range(32767, 4096));
      endcase
      return w;
   endfunction

   // Present one word, holding it until the block takes it. Valid stays
   // high on return so that back-to-back words need no extra drive.
   task automatic send_word(req_type w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_dirs.push_back(bend_ray(w));
      @(negedge clock);
   endtask

   // Receiver: toggle ready at random on every falling edge.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each taken result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dirs.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_data);
            fail_count++;
         end else begin
            want = pending_dirs.pop_front();
            if (rsp_data.out_x !== want.out_x) begin
               $error("out_x expected %0d got %0d", want.out_x, rsp_data.out_x);
               fail_count++;
            end
            if (rsp_data.out_y !== want.out_y) begin
               $error("out_y expected %0d got %0d", want.out_y, rsp_data.out_y);
               fail_count++;
            end
            if (rsp_data.out_z !== want.out_z) begin
               $error("out_z expected %0d got %0d", want.out_z, rsp_data.out_z);
               fail_count++;
            end
            if (rsp_data.internal_reflection !== want.internal_reflection) begin
               $error("internal_reflection expected %0b got %0b",
                      want.internal_reflection, rsp_data.internal_reflection);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   vec_row_type vec_rows[$];

   initial begin
      vec_row_type row;
      rsp_type     chk;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      fail_count = 0;
      idle_cycles = 0;
      send_idle_pct = 29;
      recv_idle_pct = 48;

      // Directed table; typed expectations only where obvious.
      row.typed = 1'b1;
      row.word = make_word(CMD_REFLECT, 0, 0, -16384, 0, 0, 16384, 4096, 4096);
      row.want = make_dir(0, 0, 16384, 1'b0); vec_rows.push_back(row);
      row.word = make_word(CMD_REFLECT, 16384, 0, 0, 0, 0, 16384, 4096, 4096);
      row.want = make_dir(16384, 0, 0, 1'b0); vec_rows.push_back(row);
      row.word = make_word(CMD_REFLECT, -16384, -16384, -16384, 0, 0, 0, 0, 0);
      row.want = make_dir(-16384, -16384, -16384, 1'b0); vec_rows.push_back(row);
      // equal indices pass straight through
      row.word = make_word(CMD_REFRACT, 0, 0, -16384, 0, 0, 16384, 4096, 4096);
      row.want = make_dir(0, 0, -16384, 1'b0); vec_rows.push_back(row);
      // grazing from dense to thin: total internal reflection
      row.word = make_word(CMD_REFRACT, 16384, 0, 0, 0, 0, 16384, 8192, 4096);
      row.want = make_dir(16384, 0, 0, 1'b1); vec_rows.push_back(row);
      row.typed = 1'b0;
      row.word = make_word(CMD_REFRACT, 11585, 0, -11585, 0, 0, 16384, 6144, 4096);
      vec_rows.push_back(row);
      row.word = make_word(CMD_REFRACT, 11585, 0, -11585, 0, 0, 16384, 4096, 6144);
      vec_rows.push_back(row);
      // zero target index, eta saturates
      row.word = make_word(CMD_REFRACT, 100, 0, -16384, 0, 0, 16384, 32767, 0);
      vec_rows.push_back(row);
      row.word = make_word(CMD_REFRACT, 0, 0, -16384, 0, 0, 16384, 32767, 4096);
      vec_rows.push_back(row);
      // non-unit vectors: clamped cos_i, saturated outputs
      row.word = make_word(CMD_REFRACT, -32768, 32767, -32768, 32767, -32768, 32767,
                           32767, 32767);
      vec_rows.push_back(row);
      row.word = make_word(CMD_REFLECT, 32767, 32767, 32767, 32767, 32767, 32767,
                           0, 0);
      vec_rows.push_back(row);
      row.word = make_word(CMD_REFLECT, -32768, -32768, -32768, -32768, -32768,
                           -32768, 32767, 32767);
      vec_rows.push_back(row);
      // exactly at the critical angle boundary region
      row.word = make_word(CMD_REFRACT, 8192, 0, -14189, 0, 0, 16384, 8192, 4096);
      vec_rows.push_back(row);
      row.word = make_word(CMD_REFRACT, 0, 16384, 0, 0, -16384, 0, 4096, 32767);
      vec_rows.push_back(row);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (vec_rows[k]) begin
         if (vec_rows[k].typed) begin
            chk = bend_ray(vec_rows[k].word);
            if (chk !== vec_rows[k].want) begin
               $error("table row %0d expected %h computed %h", k, vec_rows[k].want, chk);
               fail_count++;
            end
         end
         send_word(vec_rows[k].word);
      end

      // Drain fully once before the random part.
      req_valid <= 1'b0;
      while (pending_dirs.size() != 0) @(negedge clock);

      for (int k = 0; k < RandWords; k++) begin
         if (k == RandWords / 3) begin
            send_idle_pct = 48;
            recv_idle_pct = 29;
         end
         if (k == 2 * RandWords / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_word(rand_word());
      end

      req_valid <= 1'b0;
      while (pending_dirs.size() != 0) @(negedge clock);
      repeat (PipeDepth + 8) @(negedge clock);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
